FILE: hdl/stsa_pkg.sv
// Package for the segment tree slot allocator.
// Holds the shared widths, register indexes, opcode and status codes, and controller states.
// No dependencies.
`default_nettype none

package stsa_pkg;

	localparam int unsigned SLOTS_DEFAULT = 256;
	localparam int unsigned ADDR_W        = 32;
	localparam int unsigned SLOT_INDEX_W  = 8;
	localparam int unsigned CFG_DATA_W    = 32;
	localparam int unsigned SIZE_LOG2_W   = 5;

	localparam logic [SIZE_LOG2_W-1:0] SLOT_SIZE_LOG2_RESET = 5'd3;

	typedef enum logic [0:0] {
		REG_BASE_ADDRESS   = 1'b0,
		REG_SLOT_SIZE_LOG2 = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_OUTSIDE   = 2'd2,
		STATUS_NOT_ALLOC = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROOT,
		ST_DESCEND,
		ST_MAP,
		ST_LEAF,
		ST_ASCEND,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

FILE: hdl/stsa_if.sv
// Request and response channel interfaces of the slot allocator.
// Depends on stsa_pkg for the field widths and code types.
`default_nettype none

interface stsa_req_if import stsa_pkg::*; ();
	logic                valid;
	logic                ready;
	opcode_t             opcode;
	logic [ADDR_W-1:0]   freed_address;

	modport source (output valid, opcode, freed_address, input ready);
	modport sink   (input valid, opcode, freed_address, output ready);
endinterface

interface stsa_rsp_if import stsa_pkg::*; ();
	logic                     valid;
	logic                     ready;
	status_t                  status;
	logic [ADDR_W-1:0]        block_address;
	logic [SLOT_INDEX_W-1:0]  slot_index;

	modport source (output valid, status, block_address, slot_index, input ready);
	modport sink   (input valid, status, block_address, slot_index, output ready);
endinterface

`default_nettype wire

FILE: hdl/segment_tree_slot_allocator_unit.sv
// Top level of the segment tree slot allocator.
// Depends on stsa_pkg, the channel interfaces in stsa_if and the RAM in stsa_ram.
//
// The block hands out and takes back fixed-size slots of a pool that starts at the
// base address. Requests arrive on the req channel (opcode, freed_address) and every
// request produces exactly one response on the rsp channel (status, block_address,
// slot_index). A transfer happens on a rising edge where valid and ready are both high.
// The two configuration registers are written through cfg_we, cfg_index and cfg_data
// and must only change while no request is in flight.
//
// Occupancy lives in one RAM of used counts laid out as a binary tree. An allocate
// reads the root and then one node per tree level on the way down. A free maps the
// address to a slot and walks back up one level per cycle. The single RAM read per
// tree level paces both walks, and one request is handled at a time: the next
// request is taken in the cycle after the response is loaded.
//
// After reset the tree is initialized by a sweep over all 2 * 2^ceil(log2(SLOTS)) - 1
// nodes, one node per cycle, during which req.ready stays low; configuration writes
// are taken during the sweep. The response sits in an output register, so a stalled
// receiver only holds the block once the next response is ready to be loaded.
`default_nettype none

module segment_tree_slot_allocator_unit import stsa_pkg::*; #(
	parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_reg_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	stsa_req_if.sink              req,
	stsa_rsp_if.source            rsp
);

	// Tree geometry: leaves are padded up to a power of two, node 1 is the root and
	// node LEAF_SPAN + s is the leaf of slot s.
	localparam int unsigned SLOT_W    = $clog2(SLOTS);
	localparam int unsigned NODE_W    = SLOT_W + 1;
	localparam int unsigned CNT_W     = SLOT_W + 1;
	localparam int unsigned DEPTH     = 1 << NODE_W;
	localparam int unsigned IDX_EXT_W = (SLOT_W > SLOT_INDEX_W) ? SLOT_W : SLOT_INDEX_W;

	localparam logic [CNT_W-1:0]  LEAF_SPAN = {1'b1, {SLOT_W{1'b0}}};
	localparam logic [CNT_W-1:0]  SLOTS_CNT = CNT_W'(SLOTS);
	localparam logic [ADDR_W-1:0] SLOTS_ADR = ADDR_W'(SLOTS);
	localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);
	localparam logic [NODE_W-1:0] LAST_NODE = {NODE_W{1'b1}};

	// Configuration registers.
	logic [ADDR_W-1:0]      base_q;
	logic [SIZE_LOG2_W-1:0] size_log2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			size_log2_q <= SLOT_SIZE_LOG2_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE_ADDRESS:   base_q      <= cfg_data[ADDR_W-1:0];
				REG_SLOT_SIZE_LOG2: size_log2_q <= cfg_data[SIZE_LOG2_W-1:0];
			endcase
		end
	end

	// Tree memory.
	logic              rd_en;
	logic [NODE_W-1:0] rd_addr;
	logic [CNT_W-1:0]  rd_data;
	logic              wr_en;
	logic [NODE_W-1:0] wr_addr;
	logic [CNT_W-1:0]  wr_data;

	stsa_ram #(
		.WIDTH (CNT_W),
		.DEPTH (DEPTH)
	) u_tree_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Controller state.
	state_t            state_q, state_d;
	logic [NODE_W-1:0] node_q, node_d;
	logic [CNT_W-1:0]  clr_span_q, clr_span_d;
	logic [CNT_W-1:0]  clr_lo_q, clr_lo_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [CNT_W-1:0]  half_q, half_d;
	opcode_t           op_q;
	logic [ADDR_W-1:0] addr_q;
	status_t           status_q;
	logic [SLOT_W-1:0] slot_q;

	logic    req_ready;
	logic    res_load;
	status_t res_status;
	logic [SLOT_W-1:0] res_slot;
	logic    out_load;

	// Clearing sweep: each node starts out holding the number of padding leaves
	// below it. The sweep visits nodes level by level, tracking the first leaf
	// covered by the node and the leaf span of the level.
	logic [CNT_W-1:0] clr_end;
	logic [CNT_W-1:0] clr_val;

	assign clr_end = clr_lo_q + clr_span_q;

	always_comb begin
		if (clr_lo_q >= SLOTS_CNT) begin
			clr_val = clr_span_q;
		end else if (clr_end > SLOTS_CNT) begin
			clr_val = clr_end - SLOTS_CNT;
		end else begin
			clr_val = '0;
		end
	end

	// Descent step: the read data is the count of the left child of node_q.
	logic [NODE_W-1:0] left_node;
	logic [NODE_W-1:0] child_node;
	logic [CNT_W-1:0]  child_cnt;
	logic              go_left;

	assign left_node  = {node_q[NODE_W-2:0], 1'b0};
	assign go_left    = rd_data < half_q;
	assign child_node = go_left ? left_node : (left_node | ROOT_NODE);
	assign child_cnt  = go_left ? rd_data : (cnt_q - rd_data);

	// Address to slot mapping for a free request.
	logic [ADDR_W-1:0] map_offset;
	logic [ADDR_W-1:0] map_slot;
	logic              map_outside;
	logic [NODE_W-1:0] map_leaf;

	assign map_offset  = addr_q - base_q;
	assign map_slot    = map_offset >> size_log2_q;
	assign map_outside = map_slot >= SLOTS_ADR;
	assign map_leaf    = {1'b1, map_slot[SLOT_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			node_q     <= ROOT_NODE;
			clr_span_q <= LEAF_SPAN;
			clr_lo_q   <= '0;
		end else begin
			state_q    <= state_d;
			node_q     <= node_d;
			clr_span_q <= clr_span_d;
			clr_lo_q   <= clr_lo_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		node_d     = node_q;
		clr_span_d = clr_span_q;
		clr_lo_d   = clr_lo_q;
		cnt_d      = cnt_q;
		half_d     = half_q;
		rd_en      = 1'b0;
		rd_addr    = node_q;
		wr_en      = 1'b0;
		wr_addr    = node_q;
		wr_data    = rd_data;
		req_ready  = 1'b0;
		res_load   = 1'b0;
		res_status = STATUS_OK;
		res_slot   = slot_q;
		out_load   = 1'b0;

		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_data = clr_val;
				node_d  = node_q + NODE_W'(1);
				if (clr_end == LEAF_SPAN) begin
					clr_span_d = clr_span_q >> 1;
					clr_lo_d   = '0;
				end else begin
					clr_lo_d = clr_end;
				end
				if (node_q == LAST_NODE) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req.valid) begin
					if (req.opcode == OP_ALLOC) begin
						rd_en   = 1'b1;
						rd_addr = ROOT_NODE;
						state_d = ST_ROOT;
					end else begin
						state_d = ST_MAP;
					end
				end
			end
			ST_ROOT: begin
				if (rd_data >= LEAF_SPAN) begin
					res_load   = 1'b1;
					res_status = STATUS_FULL;
					res_slot   = '0;
					state_d    = ST_EMIT;
				end else begin
					wr_en   = 1'b1;
					wr_addr = ROOT_NODE;
					wr_data = rd_data + CNT_W'(1);
					node_d  = ROOT_NODE;
					cnt_d   = rd_data;
					half_d  = LEAF_SPAN >> 1;
					rd_en   = 1'b1;
					rd_addr = {ROOT_NODE[NODE_W-2:0], 1'b0};
					state_d = ST_DESCEND;
				end
			end
			ST_DESCEND: begin
				wr_en   = 1'b1;
				wr_addr = child_node;
				wr_data = child_cnt + CNT_W'(1);
				if (half_q == CNT_W'(1)) begin
					res_load   = 1'b1;
					res_status = STATUS_OK;
					res_slot   = child_node[SLOT_W-1:0];
					state_d    = ST_EMIT;
				end else begin
					node_d  = child_node;
					cnt_d   = child_cnt;
					half_d  = half_q >> 1;
					rd_en   = 1'b1;
					rd_addr = {child_node[NODE_W-2:0], 1'b0};
				end
			end
			ST_MAP: begin
				res_load = 1'b1;
				if (map_outside) begin
					res_status = STATUS_OUTSIDE;
					res_slot   = '0;
					state_d    = ST_EMIT;
				end else begin
					res_status = STATUS_OK;
					res_slot   = map_slot[SLOT_W-1:0];
					rd_en      = 1'b1;
					rd_addr    = map_leaf;
					node_d     = map_leaf;
					state_d    = ST_LEAF;
				end
			end
			ST_LEAF: begin
				if (rd_data == '0) begin
					res_load   = 1'b1;
					res_status = STATUS_NOT_ALLOC;
					state_d    = ST_EMIT;
				end else begin
					wr_en   = 1'b1;
					wr_data = rd_data - CNT_W'(1);
					rd_en   = 1'b1;
					rd_addr = node_q >> 1;
					node_d  = node_q >> 1;
					state_d = ST_ASCEND;
				end
			end
			ST_ASCEND: begin
				wr_en   = 1'b1;
				wr_data = rd_data - CNT_W'(1);
				if (node_q == ROOT_NODE) begin
					state_d = ST_EMIT;
				end else begin
					rd_en   = 1'b1;
					rd_addr = node_q >> 1;
					node_d  = node_q >> 1;
				end
			end
			ST_EMIT: begin
				if (!rsp.valid || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
		endcase
	end

	// Datapath registers of the request in flight.
	always_ff @(posedge clk) begin
		cnt_q  <= cnt_d;
		half_q <= half_d;
		if (req_ready && req.valid) begin
			op_q   <= req.opcode;
			addr_q <= req.freed_address;
		end
		if (res_load) begin
			status_q <= res_status;
			slot_q   <= res_slot;
		end
	end

	// Response register. The block address is formed only for a successful allocate.
	logic                    out_valid_q;
	status_t                 out_status_q;
	logic [ADDR_W-1:0]       out_block_q;
	logic [SLOT_INDEX_W-1:0] out_slot_q;
	logic [ADDR_W-1:0]       block_addr;
	logic [IDX_EXT_W-1:0]    slot_ext;

	assign slot_ext   = IDX_EXT_W'(slot_q);
	assign block_addr = (op_q == OP_ALLOC && status_q == STATUS_OK)
		? base_q + (ADDR_W'(slot_q) << size_log2_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= status_q;
			out_block_q  <= block_addr;
			out_slot_q   <= slot_ext[SLOT_INDEX_W-1:0];
		end
	end

	assign req.ready         = req_ready;
	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.block_address = out_block_q;
	assign rsp.slot_index    = out_slot_q;

	// Node zero is outside the tree and must never be written.
	a_no_node_zero: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> wr_addr != '0)
		else $error("tree write to node zero");

	// The root count can never exceed the padded leaf count.
	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROOT) |-> rd_data <= LEAF_SPAN)
		else $error("root used count exceeds tree capacity");

	// Walking up after a valid free, every node on the path holds at least one.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ASCEND) |-> rd_data != '0)
		else $error("used count underflow on free path");

	// A read and a write never target the same node in one cycle.
	a_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> rd_addr != wr_addr)
		else $error("read and write to the same tree node");

endmodule

`default_nettype wire

FILE: hdl/stsa_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module stsa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for segment_tree_slot_allocator_unit: allocates and frees
// slots under several pool settings and checks every response against a slot-map model.
// Depends on stsa_pkg, the channel interfaces in stsa_if and the allocator RTL.
module testbench;
	import stsa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SLOTS       = SLOTS_DEFAULT;
	localparam int          CYCLE_LIMIT = 400000;
	// The longest request is a free, which walks up every tree level; this leaves ample margin.
	localparam int          SETTLE_CYCLES = 30;

	// One response as the block should present it.
	typedef struct packed {
		status_t                  status;
		logic [ADDR_W-1:0]        block_address;
		logic [SLOT_INDEX_W-1:0]  slot_index;
	} pool_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_reg_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	stsa_req_if req_ch ();
	stsa_rsp_if rsp_ch ();

	segment_tree_slot_allocator_unit #(
		.SLOTS(SLOTS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Model state. A flat occupancy map is enough: the tree of used counts in the
	// block only serves to find the lowest free slot, which a linear scan finds too.
	logic [SLOTS-1:0]       slot_busy;
	logic [ADDR_W-1:0]      pool_base;
	logic [SIZE_LOG2_W-1:0] size_log2;

	pool_result_t pending_responses[$];

	bit idle_on;
	int errors;
	int cycle_count;
	int requests_sent;
	int pools_configured;
	int status_seen[4];

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Watchdog: a hung handshake must not run forever.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d responses outstanding", $time,
				cycle_count, pending_responses.size());
			$display("testbench: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Reference behavior
	// ------------------------------------------------------------------

	function automatic int lowest_free_slot();
		for (int i = 0; i < SLOTS; i++)
			if (!slot_busy[i])
				return i;
		return -1;
	endfunction

	// Finds a slot in the wanted state, starting the search at a random point so the
	// frees come in no particular order. Returns -1 if there is none.
	function automatic int pick_slot(input bit want_busy);
		int start;
		int idx;
		start = $urandom_range(0, SLOTS - 1);
		for (int k = 0; k < SLOTS; k++) begin
			idx = (start + k) % SLOTS;
			if (slot_busy[idx] == want_busy)
				return idx;
		end
		return -1;
	endfunction

	// Byte address inside the given slot, optionally at a random offset within it, so
	// that unaligned frees get exercised. Wraps modulo 2^32 like the block does.
	function automatic logic [ADDR_W-1:0] slot_address(input int slot, input bit jitter);
		logic [ADDR_W-1:0] in_slot;
		in_slot = jitter ? ($urandom & ((32'd1 << size_log2) - 32'd1)) : '0;
		return pool_base + (32'(slot) << size_log2) + in_slot;
	endfunction

	// Applies one accepted request to the model and gives the response it must cause.
	task automatic model_request(input opcode_t op, input logic [ADDR_W-1:0] addr,
			output pool_result_t r);
		logic [ADDR_W-1:0] offset;
		logic [ADDR_W-1:0] slot_no;
		int first_free;
		r = '0;
		r.status = STATUS_OK;
		if (op == OP_ALLOC) begin
			first_free = lowest_free_slot();
			if (first_free < 0) begin
				r.status = STATUS_FULL;
			end else begin
				slot_busy[first_free] = 1'b1;
				r.slot_index = SLOT_INDEX_W'(first_free);
				r.block_address = pool_base + (32'(first_free) << size_log2);
			end
		end else begin
			offset = addr - pool_base;
			slot_no = offset >> size_log2;
			if (slot_no >= SLOTS) begin
				r.status = STATUS_OUTSIDE;
			end else begin
				r.slot_index = slot_no[SLOT_INDEX_W-1:0];
				if (!slot_busy[slot_no])
					r.status = STATUS_NOT_ALLOC;
				else
					slot_busy[slot_no] = 1'b0;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Channel drivers and response checker
	// ------------------------------------------------------------------

	// Offers one request and returns at the falling edge after its transfer. Valid is
	// left high so back-to-back requests keep it high; wait_for_responses lowers it.
	// With idling on, a random gap with junk payload may come first.
	task automatic send_request(input opcode_t op, input logic [ADDR_W-1:0] addr);
		pool_result_t predicted;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			req_ch.opcode <= opcode_t'($urandom_range(0, 1));
			req_ch.freed_address <= $urandom;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.freed_address <= addr;
		do
			@(posedge clk);
		while (!req_ch.ready);
		// The transfer happened at this edge, so the model moves on now.
		model_request(op, addr, predicted);
		pending_responses.push_back(predicted);
		requests_sent++;
		@(negedge clk);
	endtask

	// Stops offering requests and waits until every predicted response has arrived.
	task automatic wait_for_responses();
		req_ch.valid <= 1'b0;
		while (pending_responses.size() != 0)
			@(negedge clk);
	endtask

	// Both registers are written, base address first; no request is in flight here.
	task automatic set_pool(input logic [ADDR_W-1:0] base, input logic [SIZE_LOG2_W-1:0] log2);
		cfg_we <= 1'b1;
		cfg_index <= REG_BASE_ADDRESS;
		cfg_data <= base;
		@(negedge clk);
		cfg_index <= REG_SLOT_SIZE_LOG2;
		cfg_data <= CFG_DATA_W'(log2);
		@(negedge clk);
		cfg_we <= 1'b0;
		pool_base = base;
		size_log2 = log2;
		pools_configured++;
	endtask

	// The receiver holds ready low for random bursts while idling is on, and is always
	// ready otherwise.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	// Every response transfer is matched against the oldest outstanding prediction.
	always @(posedge clk) begin
		pool_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_responses.size() == 0) begin
				$display("%0t: unexpected response: status %0d block_address %h slot_index %0d",
					$time, rsp_ch.status, rsp_ch.block_address, rsp_ch.slot_index);
				errors++;
			end else begin
				want = pending_responses.pop_front();
				status_seen[want.status]++;
				if (rsp_ch.status !== want.status) begin
					$display("%0t: status mismatch: expected %0d, actual %0d", $time,
						want.status, rsp_ch.status);
					errors++;
				end
				if (rsp_ch.block_address !== want.block_address) begin
					$display("%0t: block_address mismatch: expected %h, actual %h", $time,
						want.block_address, rsp_ch.block_address);
					errors++;
				end
				if (rsp_ch.slot_index !== want.slot_index) begin
					$display("%0t: slot_index mismatch: expected %0d, actual %0d", $time,
						want.slot_index, rsp_ch.slot_index);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Default pool at address 0 with 8-byte slots: lowest-free allocation, a good free,
	// a double free, an unaligned free, the last slot, and addresses past the pool.
	task automatic test_basic_alloc_free();
		set_pool(32'h0000_0000, 5'd3);
		send_request(OP_ALLOC, $urandom);
		send_request(OP_ALLOC, $urandom);
		send_request(OP_ALLOC, $urandom);
		send_request(OP_FREE, 32'd8);
		send_request(OP_FREE, 32'd8);
		send_request(OP_FREE, 32'd19);
		// The hole left at slot 1 must be refilled before anything higher.
		send_request(OP_ALLOC, 32'hFFFF_FFFF);
		send_request(OP_FREE, 32'd2047);
		send_request(OP_FREE, 32'd2048);
		send_request(OP_FREE, 32'hFFFF_FFFF);
	endtask

	// A base near the top of the address space makes slot addresses wrap past zero, and
	// an address just below the base wraps to a huge offset that lies outside the pool.
	// The second setting uses 64 KiB slots.
	task automatic test_address_wrap();
		wait_for_responses();
		set_pool(32'hFFFF_FFF0, 5'd3);
		send_request(OP_ALLOC, 32'h0);
		send_request(OP_ALLOC, 32'h0);
		send_request(OP_FREE, 32'h0000_0000);
		send_request(OP_FREE, 32'hFFFF_FFEF);
		wait_for_responses();
		set_pool(32'h8000_0000, 5'd16);
		send_request(OP_FREE, 32'h8001_0005);
		send_request(OP_FREE, 32'h0000_0000);
		send_request(OP_ALLOC, 32'h0);
		send_request(OP_FREE, 32'h80FF_FFFF);
	endtask

	// Fills the whole pool, asks for more while full, then returns every slot in random
	// order with unaligned addresses and an occasional double free.
	task automatic test_fill_and_empty();
		int slot;
		wait_for_responses();
		idle_on = 1'b1;
		set_pool($urandom, 5'($urandom_range(3, 16)));
		while (lowest_free_slot() >= 0)
			send_request(OP_ALLOC, $urandom);
		repeat (3)
			send_request(OP_ALLOC, $urandom);
		// Let the pipeline run dry with the pool full before the frees start.
		wait_for_responses();
		while (pick_slot(1'b1) >= 0) begin
			slot = pick_slot(1'b0);
			if (slot >= 0 && $urandom_range(0, 15) == 0)
				send_request(OP_FREE, slot_address(slot, 1'b1));
			send_request(OP_FREE, slot_address(pick_slot(1'b1), 1'b1));
		end
	endtask

	// Mixed traffic under one pool setting: mostly allocations and frees of slots in use,
	// plus double frees, addresses below the base and fully random requests.
	task automatic test_random_mix(input int n_items, input logic [ADDR_W-1:0] base,
			input logic [SIZE_LOG2_W-1:0] log2, input bit idle);
		int pick;
		int slot;
		wait_for_responses();
		set_pool(base, log2);
		idle_on = idle;
		repeat (n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_request(OP_ALLOC, $urandom);
			end else if (pick < 80) begin
				slot = pick_slot(1'b1);
				if (slot < 0)
					send_request(OP_ALLOC, $urandom);
				else
					send_request(OP_FREE, slot_address(slot, 1'b1));
			end else if (pick < 88) begin
				slot = pick_slot(1'b0);
				if (slot < 0)
					slot = pick_slot(1'b1);
				send_request(OP_FREE, slot_address(slot, 1'b1));
			end else if (pick < 94) begin
				send_request(OP_FREE, pool_base - 32'd1 - 32'($urandom_range(0, 4095)));
			end else begin
				send_request(opcode_t'($urandom_range(0, 1)), $urandom);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_BASE_ADDRESS;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_ALLOC;
		req_ch.freed_address = '0;
		idle_on = 1'b1;
		errors = 0;
		cycle_count = 0;
		requests_sent = 0;
		pools_configured = 0;
		status_seen = '{0, 0, 0, 0};
		slot_busy = '0;
		pool_base = '0;
		size_log2 = SLOT_SIZE_LOG2_RESET;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// The block clears its tree after reset with ready low; send_request simply
		// waits for ready, and the register writes are accepted meanwhile.
		test_basic_alloc_free();
		test_address_wrap();
		test_fill_and_empty();
		// Byte-sized slots at address zero, then the widest shift the field can hold,
		// where slot addresses alias modulo 2^32 and nothing lies outside the pool.
		test_random_mix(60, 32'h0000_0000, 5'd0, 1'b1);
		test_random_mix(50, 32'hFFFF_FFFF, 5'd31, 1'b1);
		test_random_mix(60, $urandom, 5'd16, 1'b1);
		// The closing stretch runs at full rate on both channels.
		test_random_mix(80, $urandom, 5'd3, 1'b0);

		wait_for_responses();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Covered %0d requests over %0d pool settings in %0d cycles.",
			requests_sent, pools_configured, cycle_count);
		$display("Responses: %0d ok, %0d pool full, %0d outside pool, %0d not allocated.",
			status_seen[STATUS_OK], status_seen[STATUS_FULL], status_seen[STATUS_OUTSIDE],
			status_seen[STATUS_NOT_ALLOC]);
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
